/* rtl/qbm_pkg.sv */
// Shared types, codes and version tables for the QR byte-mode codeword builder.
`timescale 1ns / 1ps
package qbm_pkg;

   localparam int unsigned VER_LIMIT       = 40;
   localparam int unsigned MAX_VERSION_DEF = 40;
   localparam int unsigned QUEUE_DEPTH     = 2;
   localparam int unsigned VER_W           = 6;
   localparam int unsigned LEN_W           = 12;
   localparam int unsigned CW_W            = 8;
   localparam int unsigned ST_W            = 2;
   localparam int unsigned MODE_W          = 2;
   localparam int unsigned VIDX_W          = $clog2(VER_LIMIT);

   localparam logic [MODE_W-1:0] MODE_START = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PULL  = 2'd2;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [ST_W-1:0] ST_SEQUENCE  = 2'd2;

   localparam logic [3:0]      MODE_NIBBLE = 4'b0100;
   localparam logic [CW_W-1:0] PAD_A       = 8'd236;
   localparam logic [CW_W-1:0] PAD_B       = 8'd17;
   localparam logic [VER_W-1:0] LONG_COUNT_VER = 6'd10;

   localparam logic [LEN_W-1:0] CAP_BYTES [VER_LIMIT] = '{
      12'd17,   12'd32,   12'd53,   12'd78,   12'd106,  12'd134,  12'd154,  12'd192,
      12'd230,  12'd271,  12'd321,  12'd367,  12'd425,  12'd458,  12'd520,  12'd586,
      12'd644,  12'd718,  12'd792,  12'd858,  12'd929,  12'd1003, 12'd1091, 12'd1171,
      12'd1273, 12'd1367, 12'd1465, 12'd1528, 12'd1628, 12'd1732, 12'd1840, 12'd1952,
      12'd2068, 12'd2188, 12'd2303, 12'd2431, 12'd2563, 12'd2699, 12'd2809, 12'd2953
   };

   localparam logic [LEN_W-1:0] DATA_CW [VER_LIMIT] = '{
      12'd19,   12'd34,   12'd55,   12'd80,   12'd108,  12'd136,  12'd156,  12'd194,
      12'd232,  12'd274,  12'd324,  12'd370,  12'd428,  12'd461,  12'd523,  12'd589,
      12'd647,  12'd721,  12'd795,  12'd861,  12'd932,  12'd1006, 12'd1094, 12'd1174,
      12'd1276, 12'd1370, 12'd1468, 12'd1531, 12'd1631, 12'd1735, 12'd1843, 12'd1955,
      12'd2071, 12'd2191, 12'd2306, 12'd2434, 12'd2566, 12'd2702, 12'd2812, 12'd2956
   };

   // One queued command: one or two output transfers.
   typedef struct packed {
      logic [CW_W-1:0]  cw0;
      logic [CW_W-1:0]  cw1;
      logic             two;
      logic             last;
      logic [VER_W-1:0] version;
      logic [ST_W-1:0]  status;
   } cmd_type;

endpackage

/* rtl/qr_byte_mode_data_codewords.sv */
// Top level of the QR byte-mode data codeword builder, correction level L.
// Each accepted item's result is registered in the command queue before it is offered.
// Throughput: one item per cycle while the command queue has room; a start with a 16-bit count
// field uses two output transfers, so the output port sets the rate for those items.
// Reset: synchronous, clears the symbol state and empties the command queue.
`timescale 1ns / 1ps
module qr_byte_mode_data_codewords #(
   parameter int unsigned MAX_VERSION = qbm_pkg::MAX_VERSION_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [qbm_pkg::MODE_W-1:0]   req_mode,
   input  logic [qbm_pkg::LEN_W-1:0]    req_msg_length,
   input  logic [qbm_pkg::CW_W-1:0]     req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [qbm_pkg::CW_W-1:0]     rsp_codeword,
   output logic                         rsp_last_codeword,
   output logic [qbm_pkg::VER_W-1:0]    rsp_version,
   output logic [qbm_pkg::ST_W-1:0]     rsp_status
);
   import qbm_pkg::*;

   logic    q_full;
   logic    q_not_empty;
   logic    push;
   logic    pop;
   cmd_type push_cmd;
   cmd_type head;

   qbm_front #(
      .MAX_VERSION(MAX_VERSION)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_msg_length(req_msg_length),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   qbm_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (q_full),
      .not_empty(q_not_empty),
      .head     (head)
   );

   qbm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .not_empty        (q_not_empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_codeword     (rsp_codeword),
      .rsp_last_codeword(rsp_last_codeword),
      .rsp_version      (rsp_version),
      .rsp_status       (rsp_status)
   );

endmodule

/* rtl/qbm_front.sv */
// Front end: classifies items, tracks the symbol state and builds output commands.
`timescale 1ns / 1ps
module qbm_front #(
   parameter int unsigned MAX_VERSION = qbm_pkg::MAX_VERSION_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [qbm_pkg::MODE_W-1:0]   req_mode,
   input  logic [qbm_pkg::LEN_W-1:0]    req_msg_length,
   input  logic [qbm_pkg::CW_W-1:0]     req_data_byte,
   input  logic                         q_full,
   output logic                         push,
   output qbm_pkg::cmd_type             push_cmd
);
   import qbm_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DATA,
      PH_CLOSE,
      PH_PAD
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [VER_W-1:0]  ver_ff, ver_in;
   logic [LEN_W-1:0]  bytes_ff, bytes_in;
   logic [LEN_W-1:0]  cwl_ff, cwl_in;
   logic [3:0]        carry_ff, carry_in;
   logic              pad_ff, pad_in;

   logic              accept;
   logic [VER_W-1:0]  fit_ver;
   logic [VIDX_W-1:0] fit_idx;
   logic [LEN_W-1:0]  total_cw;
   logic [LEN_W-1:0]  cwl_dec;
   logic [LEN_W-1:0]  bytes_dec;
   logic              last_cw;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;

   always_comb begin
      fit_ver = '0;
      for (int i = int'(MAX_VERSION) - 1; i >= 0; i--) begin
         if (CAP_BYTES[i] >= req_msg_length) begin
            fit_ver = VER_W'(i + 1);
         end
      end
   end

   assign fit_idx   = VIDX_W'(fit_ver - 1'b1);
   assign total_cw  = DATA_CW[fit_idx];
   assign cwl_dec   = cwl_ff - 1'b1;
   assign bytes_dec = bytes_ff - 1'b1;
   assign last_cw   = (cwl_dec == '0);

   always_comb begin
      phase_in = phase_ff;
      ver_in   = ver_ff;
      bytes_in = bytes_ff;
      cwl_in   = cwl_ff;
      carry_in = carry_ff;
      pad_in   = pad_ff;
      push     = accept;
      push_cmd = '{cw0: '0, cw1: '0, two: 1'b0, last: 1'b0,
                   version: ver_ff, status: ST_SEQUENCE};
      priority if (req_mode == MODE_START) begin
         if (fit_ver == '0) begin
            phase_in = PH_IDLE;
            ver_in   = '0;
            bytes_in = '0;
            cwl_in   = '0;
            carry_in = '0;
            pad_in   = 1'b0;
            push_cmd.version = '0;
            push_cmd.status  = ST_TOO_LARGE;
         end else begin
            ver_in   = fit_ver;
            bytes_in = req_msg_length;
            pad_in   = 1'b0;
            carry_in = req_msg_length[3:0];
            phase_in = (req_msg_length != '0) ? PH_DATA : PH_CLOSE;
            push_cmd.version = fit_ver;
            push_cmd.status  = ST_OK;
            if (fit_ver < LONG_COUNT_VER) begin
               cwl_in       = total_cw - LEN_W'(1);
               push_cmd.cw0 = {MODE_NIBBLE, req_msg_length[7:4]};
            end else begin
               // 16-bit count of a 12-bit length: top nibble is zero
               cwl_in       = total_cw - LEN_W'(2);
               push_cmd.cw0 = {MODE_NIBBLE, 4'b0000};
               push_cmd.cw1 = req_msg_length[11:4];
               push_cmd.two = 1'b1;
            end
         end
      end else if (req_mode == MODE_BYTE && phase_ff == PH_DATA) begin
         push_cmd.cw0    = {carry_ff, req_data_byte[7:4]};
         push_cmd.last   = last_cw;
         push_cmd.status = ST_OK;
         carry_in = req_data_byte[3:0];
         cwl_in   = cwl_dec;
         bytes_in = bytes_dec;
         if (bytes_dec == '0) begin
            phase_in = PH_CLOSE;
         end
         if (last_cw) begin
            phase_in = PH_IDLE;
         end
      end else if (req_mode == MODE_PULL && (phase_ff == PH_CLOSE || phase_ff == PH_PAD)) begin
         push_cmd.last   = last_cw;
         push_cmd.status = ST_OK;
         cwl_in = cwl_dec;
         if (phase_ff == PH_CLOSE) begin
            push_cmd.cw0 = {carry_ff, 4'b0000};
            carry_in     = '0;
            phase_in     = PH_PAD;
         end else begin
            push_cmd.cw0 = pad_ff ? PAD_B : PAD_A;
            pad_in       = ~pad_ff;
         end
         if (last_cw) begin
            phase_in = PH_IDLE;
         end
      end else begin
         // out of sequence: state holds
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ver_ff   <= '0;
         bytes_ff <= '0;
         cwl_ff   <= '0;
         carry_ff <= '0;
         pad_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         ver_ff   <= ver_in;
         bytes_ff <= bytes_in;
         cwl_ff   <= cwl_in;
         carry_ff <= carry_in;
         pad_ff   <= pad_in;
      end
   end

endmodule

/* rtl/qbm_queue.sv */
// Short command queue between front and back ends.
`timescale 1ns / 1ps
module qbm_queue #(
   parameter int unsigned DEPTH = qbm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  qbm_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output qbm_pkg::cmd_type head
);
   import qbm_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* rtl/qbm_back.sv */
// Back end: expands queued commands into one or two output transfers.
`timescale 1ns / 1ps
module qbm_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         not_empty,
   input  qbm_pkg::cmd_type             head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [qbm_pkg::CW_W-1:0]     rsp_codeword,
   output logic                         rsp_last_codeword,
   output logic [qbm_pkg::VER_W-1:0]    rsp_version,
   output logic [qbm_pkg::ST_W-1:0]     rsp_status
);
   import qbm_pkg::*;

   logic second_ff, second_in;
   logic xfer;

   assign rsp_valid         = not_empty;
   assign xfer              = not_empty & ~rsp_stall;
   assign pop               = xfer & (~head.two | second_ff);
   assign rsp_codeword      = second_ff ? head.cw1 : head.cw0;
   assign rsp_last_codeword = head.last;
   assign rsp_version       = head.version;
   assign rsp_status        = head.status;

   always_comb begin
      second_in = second_ff;
      if (xfer) begin
         second_in = head.two & ~second_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule
